FILE: rtl/fourth_order_iir_lowpass_assert.svh
// ----------------------------------------------------------------------------
// fourth_order_iir_lowpass assertion macros
// concurrent checks on the rising edge of clock, compiled out under SYNTH
// ----------------------------------------------------------------------------
`ifndef FOURTH_ORDER_IIR_LOWPASS_ASSERT_SVH
`define FOURTH_ORDER_IIR_LOWPASS_ASSERT_SVH

`ifndef SYNTH
// check that is held off while reset is high
`define IIR4LP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// check that also covers reset cycles
`define IIR4LP_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define IIR4LP_ASSERT(lbl, prop, msg)
`define IIR4LP_ASSERT_RST(lbl, prop, msg)
`endif

`endif

FILE: rtl/iir4lp_pkg.sv
// ----------------------------------------------------------------------------
// iir4lp_pkg
// widths, register indexes and shared types of the fourth-order iir low-pass
// ----------------------------------------------------------------------------
`default_nettype none

package iir4lp_pkg;

   localparam int DATA_W     = 32;            // q16.16 samples
   localparam int COEF_W     = 32;            // q4.28 coefficients
   localparam int HIST_DEPTH = 4;
   localparam int TAPS_W     = DATA_W + 4;    // binomial sum, weights total 16
   localparam int GPROD_W    = COEF_W + TAPS_W;
   localparam int FPROD_W    = COEF_W + DATA_W;
   localparam int ACC_W      = GPROD_W + 2;
   localparam int FRAC_SHIFT = 28;
   localparam int RND_W      = ACC_W - FRAC_SHIFT;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN           = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FEEDBACK_ONE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FEEDBACK_TWO   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FEEDBACK_THREE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FEEDBACK_FOUR  = 3'd4;

   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_SHIFT - 1);

   typedef logic [DATA_W-1:0] sample_type;
   typedef sample_type [HIST_DEPTH-1:0] hist_type;   // index 0 newest

   typedef struct packed {
      logic signed [COEF_W-1:0] gain;
      logic signed [COEF_W-1:0] fb_one;
      logic signed [COEF_W-1:0] fb_two;
      logic signed [COEF_W-1:0] fb_three;
      logic signed [COEF_W-1:0] fb_four;
   } coef_type;

endpackage

`default_nettype wire

FILE: rtl/iir4lp_csr.sv
// ----------------------------------------------------------------------------
// iir4lp_csr
// coefficient registers, written through a plain index/data port
// ----------------------------------------------------------------------------
`default_nettype none

module iir4lp_csr
   import iir4lp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [COEF_W-1:0]    csr_wdata,
   output coef_type                  coef
);

   coef_type coef_ff;
   coef_type coef_in;

   always_comb begin
      coef_in = coef_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_GAIN:           coef_in.gain     = csr_wdata;
            CSR_FEEDBACK_ONE:   coef_in.fb_one   = csr_wdata;
            CSR_FEEDBACK_TWO:   coef_in.fb_two   = csr_wdata;
            CSR_FEEDBACK_THREE: coef_in.fb_three = csr_wdata;
            CSR_FEEDBACK_FOUR:  coef_in.fb_four  = csr_wdata;
            default:            coef_in          = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign coef = coef_ff;

endmodule

`default_nettype wire

FILE: rtl/iir4lp_arith.sv
// ----------------------------------------------------------------------------
// iir4lp_arith
// one filter step: binomial taps, five products, round and saturate
// ----------------------------------------------------------------------------
`default_nettype none

module iir4lp_arith
   import iir4lp_pkg::*;
(
   input  wire logic       restart,
   input  wire sample_type sample,
   input  wire hist_type   in_hist,
   input  wire hist_type   out_hist,
   input  wire coef_type   coef,
   output sample_type      filtered
);

   logic signed [DATA_W-1:0]  x;
   logic signed [DATA_W-1:0]  xh [HIST_DEPTH];
   logic signed [DATA_W-1:0]  yh [HIST_DEPTH];
   logic signed [TAPS_W-1:0]  taps;
   logic signed [GPROD_W-1:0] p_gain;
   logic signed [FPROD_W-1:0] p_one;
   logic signed [FPROD_W-1:0] p_two;
   logic signed [FPROD_W-1:0] p_three;
   logic signed [FPROD_W-1:0] p_four;
   logic signed [ACC_W-1:0]   acc;
   logic signed [RND_W-1:0]   rounded;
   logic                      in_range;

   assign x = $signed(sample);

   // restart loads both histories with the current sample
   always_comb begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
         xh[i] = restart ? x : $signed(in_hist[i]);
         yh[i] = restart ? x : $signed(out_hist[i]);
      end
   end

   assign taps = TAPS_W'(x)
               + (TAPS_W'(xh[0]) <<< 2)
               + (TAPS_W'(xh[1]) <<< 2) + (TAPS_W'(xh[1]) <<< 1)
               + (TAPS_W'(xh[2]) <<< 2)
               + TAPS_W'(xh[3]);

   assign p_gain  = coef.gain     * taps;
   assign p_one   = coef.fb_one   * yh[0];
   assign p_two   = coef.fb_two   * yh[1];
   assign p_three = coef.fb_three * yh[2];
   assign p_four  = coef.fb_four  * yh[3];

   assign acc = ACC_W'(p_gain)
              - ACC_W'(p_one) - ACC_W'(p_two)
              - ACC_W'(p_three) - ACC_W'(p_four)
              + ROUND_HALF;

   assign rounded = acc[ACC_W-1:FRAC_SHIFT];

   // fits when all bits above the sample sign agree with it
   assign in_range = (rounded[RND_W-1:DATA_W-1] == '0)
                  || (rounded[RND_W-1:DATA_W-1] == '1);

   always_comb begin
      if (in_range) begin
         filtered = rounded[DATA_W-1:0];
      end else if (rounded[RND_W-1]) begin
         filtered = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         filtered = {1'b0, {(DATA_W-1){1'b1}}};
      end
   end

endmodule

`default_nettype wire

FILE: rtl/fourth_order_iir_lowpass.sv
// ----------------------------------------------------------------------------
// fourth_order_iir_lowpass
// fourth-order direct-form-i low-pass filter, binomial numerator, q16.16 data
// ----------------------------------------------------------------------------
// Takes one sample per clock and returns one filtered sample per clock
// while the result side is not stalled: a beat is captured into an input
// register, the filter step runs combinationally into the result register,
// and a full result register still lets a new beat into an empty input
// register. The clock rate is set by the combinational step from the input
// register and the four-deep histories through the five coefficient
// multipliers and the 70-bit sum with round and saturate, since each output
// feeds the next sample's step. Coefficients are q4.28, already normalized.
`default_nettype none

`include "fourth_order_iir_lowpass_assert.svh"

module fourth_order_iir_lowpass
   import iir4lp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [DATA_W-1:0]    req_tdata,    // [31:0] sample
   input  wire logic                 req_tuser,    // [0] restart
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic      [DATA_W-1:0]    rsp_tdata,    // [31:0] filtered
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [COEF_W-1:0]    csr_wdata
);

   coef_type   coef;
   logic       s1_valid_ff,   s1_valid_in;
   sample_type s1_sample_ff,  s1_sample_in;
   logic       s1_restart_ff, s1_restart_in;
   logic       rsp_valid_ff,  rsp_valid_in;
   sample_type rsp_data_ff,   rsp_data_in;
   hist_type   in_hist_ff,    in_hist_in;
   hist_type   out_hist_ff,   out_hist_in;
   sample_type filtered;
   logic       advance;
   logic       take;

   iir4lp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .coef      (coef)
   );

   iir4lp_arith u_arith (
      .restart  (s1_restart_ff),
      .sample   (s1_sample_ff),
      .in_hist  (in_hist_ff),
      .out_hist (out_hist_ff),
      .coef     (coef),
      .filtered (filtered)
   );

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in   = take || (s1_valid_ff && !advance);
      s1_sample_in  = take ? req_tdata : s1_sample_ff;
      s1_restart_in = take ? req_tuser : s1_restart_ff;
      rsp_valid_in  = advance || (rsp_valid_ff && !rsp_tready);
      rsp_data_in   = advance ? filtered : rsp_data_ff;
      in_hist_in    = in_hist_ff;
      out_hist_in   = out_hist_ff;
      if (advance) begin
         in_hist_in[0]  = s1_sample_ff;
         out_hist_in[0] = filtered;
         for (int i = 1; i < HIST_DEPTH; i++) begin
            in_hist_in[i]  = s1_restart_ff ? s1_sample_ff : in_hist_ff[i-1];
            out_hist_in[i] = s1_restart_ff ? s1_sample_ff : out_hist_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         in_hist_ff   <= '0;
         out_hist_ff  <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         in_hist_ff   <= in_hist_in;
         out_hist_ff  <= out_hist_in;
      end
      s1_sample_ff  <= s1_sample_in;
      s1_restart_ff <= s1_restart_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `IIR4LP_ASSERT_RST(a_reset_clears, reset |=> !rsp_tvalid, "result valid after reset")
   `IIR4LP_ASSERT(a_advance_fills, advance |=> rsp_valid_ff, "step did not fill result")
   `IIR4LP_ASSERT(a_history_tracks, advance |=> in_hist_ff[0] == $past(s1_sample_ff), "input history missed sample")
   `IIR4LP_ASSERT(a_ready_when_empty, !rsp_valid_ff |-> req_tready, "not ready with empty result")

endmodule

`default_nettype wire
